// File: hw/rtl/midi_uart_port_message_assembler_defines.svh
// ----------------------------------------------------------------------------
// MIDI UART port message assembler: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_UART_PORT_MESSAGE_ASSEMBLER_DEFINES_SVH
`define MIDI_UART_PORT_MESSAGE_ASSEMBLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MUMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MUMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/muma_pkg.sv
// ----------------------------------------------------------------------------
// MIDI UART port message assembler: package
// Bus access codes, MIDI byte constants and the item and result types.
// ----------------------------------------------------------------------------
package muma_pkg;

  // Bus access carried by one input item.
  typedef enum logic [1:0] {
    ACT_RD_DATA = 2'd0,
    ACT_WR_DATA = 2'd1,
    ACT_RD_STAT = 2'd2,
    ACT_WR_CMD  = 2'd3
  } action_t;

  localparam logic [7:0] MIDI_PROG_MIN    = 8'hC0;
  localparam logic [7:0] MIDI_PITCH_MIN   = 8'hE0;
  localparam logic [7:0] MIDI_SYSEX_START = 8'hF0;
  localparam logic [7:0] MIDI_SYSEX_END   = 8'hF7;
  localparam logic [7:0] CMD_RESET        = 8'hFF;
  localparam logic [7:0] CMD_ACK          = 8'hFE;

  // Only status bits 7 and 6 ever change; the low six bits read as zero.
  localparam logic [1:0] STAT_RESET = 2'b10;
  localparam logic [1:0] STAT_CMD   = 2'b01;

  typedef struct packed {
    action_t    action;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        message_valid;
    logic [23:0] midi_message;
    logic        reset_pulse;
    logic        byte_rejected;
  } result_t;

endpackage

// File: hw/rtl/muma_engine.sv
// ----------------------------------------------------------------------------
// MIDI UART port message assembler: port engine
// Holds the port and assembly state and works out one access's result.
// ----------------------------------------------------------------------------
module muma_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  muma_pkg::item_t  item,
  output muma_pkg::result_t res
);
  import muma_pkg::*;

  logic [7:0]  latch_r,  latch_nxt;
  logic [1:0]  stat_r,   stat_nxt;
  logic        sysex_r,  sysex_nxt;
  logic [1:0]  need_r,   need_nxt;
  logic [23:0] buf_r,    buf_nxt;
  logic [1:0]  pos_r,    pos_nxt;

  logic        mismatch;
  logic [1:0]  slot;

  // A data byte is out of order when its kind disagrees with what is expected.
  assign mismatch = (need_r == 2'd0) != item.value[7];
  assign slot     = (pos_r > 2'd2) ? 2'd2 : pos_r;

  always_comb begin
    latch_nxt = latch_r;
    stat_nxt  = stat_r;
    sysex_nxt = sysex_r;
    need_nxt  = need_r;
    buf_nxt   = buf_r;
    pos_nxt   = pos_r;
    res       = '0;
    unique case (item.action)
      ACT_RD_DATA: begin
        res.read_byte = latch_r;
        latch_nxt     = 8'h00;
        stat_nxt      = STAT_RESET;
      end
      ACT_RD_STAT: begin
        res.read_byte = {stat_r, 6'b000000};
      end
      ACT_WR_CMD: begin
        if (item.value == CMD_RESET) begin
          res.reset_pulse = 1'b1;
          latch_nxt       = CMD_ACK;
          stat_nxt        = STAT_CMD;
        end
      end
      ACT_WR_DATA: begin
        if (mismatch && (!sysex_r || item.value == MIDI_SYSEX_END)) begin
          res.byte_rejected = 1'b1;
        end else begin
          stat_nxt[0] = 1'b0;
          priority if (!item.value[7]) begin
            // Data bytes inside system exclusive are dropped.
            if (!sysex_r) begin
              unique case (slot)
                2'd0:    buf_nxt[7:0]   = item.value;
                2'd1:    buf_nxt[15:8]  = item.value;
                default: buf_nxt[23:16] = item.value;
              endcase
              pos_nxt  = (slot == 2'd2) ? 2'd2 : slot + 2'd1;
              need_nxt = need_r - 2'd1;
              if (need_nxt == 2'd0) begin
                res.message_valid = 1'b1;
                res.midi_message  = buf_nxt;
              end
            end
          end else if (item.value < MIDI_PROG_MIN) begin
            buf_nxt  = {16'h0000, item.value};
            pos_nxt  = 2'd1;
            need_nxt = 2'd2;
          end else if (item.value < MIDI_PITCH_MIN) begin
            buf_nxt  = {16'h0000, item.value};
            pos_nxt  = 2'd1;
            need_nxt = 2'd1;
          end else if (item.value < MIDI_SYSEX_START) begin
            buf_nxt  = {16'h0000, item.value};
            pos_nxt  = 2'd1;
            need_nxt = 2'd2;
          end else if (item.value == MIDI_SYSEX_START) begin
            sysex_nxt = 1'b1;
          end else if (item.value == MIDI_SYSEX_END) begin
            sysex_nxt = 1'b0;
          end else begin
            // Other system bytes are accepted with no further effect.
            sysex_nxt = sysex_r;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= 8'h00;
      stat_r  <= STAT_RESET;
      sysex_r <= 1'b0;
      need_r  <= 2'd0;
      buf_r   <= 24'h000000;
      pos_r   <= 2'd0;
    end else if (step) begin
      latch_r <= latch_nxt;
      stat_r  <= stat_nxt;
      sysex_r <= sysex_nxt;
      need_r  <= need_nxt;
      buf_r   <= buf_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// File: hw/rtl/midi_uart_port_message_assembler.sv
// ----------------------------------------------------------------------------
// MIDI UART port message assembler: top level
// Data and status/command byte ports of a MIDI UART-mode interface that
// assemble channel messages from the bytes written to the data port.
// ----------------------------------------------------------------------------
//
// Channel  Ports                                     Direction
// -------  ----------------------------------------  ---------
// in       in_valid, in_ready, in_action, in_value    sink
// out      out_valid, out_ready, out_read_byte,       source
//          out_message_valid, out_midi_message,
//          out_reset_pulse, out_byte_rejected
//
// Every accepted access gives exactly one result, passing first through the
// input register and then through the result register.
// One access per cycle is sustained while out_ready stays high; the port
// engine's state update between the two registers keeps that pace.
// Reset (synchronous, active low) empties both registers and returns the
// port state to its power-on values, with status reading 0x80.
// When out_ready is held low the result register and the input register
// fill in turn, and then in_ready drops until a result transfer is taken.
// ----------------------------------------------------------------------------
`include "midi_uart_port_message_assembler_defines.svh"

module midi_uart_port_message_assembler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_byte,
  output logic        out_message_valid,
  output logic [23:0] out_midi_message,
  output logic        out_reset_pulse,
  output logic        out_byte_rejected
);
  import muma_pkg::*;

  // Input register: holds the accepted access until the engine consumes it.
  logic    s1_valid_r;
  item_t   s1_item_r;
  // Result register: holds the finished result until the sink takes it.
  logic    out_valid_r;
  result_t out_res_r;

  logic    s1_adv;
  result_t eng_res;
  logic [2:0] out_flags;

  // The access in the input register moves on, and changes the port state,
  // whenever the result register is empty or is being emptied this cycle.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  muma_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .item  (s1_item_r),
    .res   (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; the valid flags above qualify them.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= '{action: action_t'(in_action), value: in_value};
    end
    if (s1_adv) begin
      out_res_r <= eng_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_byte     = out_res_r.read_byte;
  assign out_message_valid = out_res_r.message_valid;
  assign out_midi_message  = out_res_r.midi_message;
  assign out_reset_pulse   = out_res_r.reset_pulse;
  assign out_byte_rejected = out_res_r.byte_rejected;

  assign out_flags = {out_message_valid, out_reset_pulse, out_byte_rejected};

  // A message, a reset request and a rejection come from different accesses.
  `MUMA_ASSERT_IMP(a_one_event, out_valid_r, $countones(out_flags) <= 1, "several events in one result")
  // A finished message always carries a status byte in its low byte.
  `MUMA_ASSERT_IMP(a_msg_status, out_valid_r && out_message_valid, out_midi_message[7], "message without status byte")
  // The packed message is zero unless a message is reported.
  `MUMA_ASSERT_IMP(a_msg_zero, out_valid_r && !out_message_valid, out_midi_message == 24'h000000, "stray message bits")
  // A waiting access is never lost while the result side is stalled.
  `MUMA_ASSERT_NXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r, "pending access dropped")

endmodule

// File: tb/midi_uart_port_message_assembler_tb.sv
// ----------------------------------------------------------------------------
// MIDI UART port message assembler: testbench
// Drives data-port, status-port and command accesses through the valid/ready
// input channel and checks every result transfer against a cycle-free
// behavioural predictor of the port pair, under several idling patterns.
// ----------------------------------------------------------------------------
module midi_uart_port_message_assembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import muma_pkg::*;

  // Every input starts at a known value; reset is held from time zero.
  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_RD_STAT;
  logic [7:0]  in_value  = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_byte;
  logic        out_message_valid;
  logic [23:0] out_midi_message;
  logic        out_reset_pulse;
  logic        out_byte_rejected;

  // Idling pressure, in percent per cycle, set by each test phase.
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  int fail_count     = 0;
  int accepted_items = 0;

  // Predicted port state, updated once per accepted input transfer.
  logic [7:0]  port_latch;
  logic [7:0]  port_status;
  logic        sysex_active;
  logic [1:0]  data_bytes_left;
  logic [23:0] msg_shadow;
  logic [1:0]  slot_index;

  // Responses predicted but not yet seen on the result channel, oldest first.
  result_t port_responses[$];

  midi_uart_port_message_assembler uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_byte     (out_read_byte),
    .out_message_valid (out_message_valid),
    .out_midi_message  (out_midi_message),
    .out_reset_pulse   (out_reset_pulse),
    .out_byte_rejected (out_byte_rejected)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // A channel status byte opens a fresh message with the status in the low
  // byte; the next data byte goes into slot one.
  function automatic void open_message(logic [7:0] status, logic [1:0] need);
    msg_shadow      = {16'h0000, status};
    slot_index      = 2'd1;
    data_bytes_left = need;
  endfunction

  // Works out the response to one bus access and advances the port state.
  function automatic result_t decode_access(action_t act, logic [7:0] v);
    result_t    r;
    logic       mismatch;
    logic [1:0] pos;
    r = '0;
    case (act)
      ACT_RD_DATA: begin
        r.read_byte = port_latch;
        port_latch  = 8'h00;
        port_status = {STAT_RESET, port_status[5:0]};
      end
      ACT_RD_STAT: begin
        r.read_byte = port_status;
      end
      ACT_WR_CMD: begin
        // Any command other than the reset request is ignored.
        if (v == CMD_RESET) begin
          r.reset_pulse = 1'b1;
          port_latch    = CMD_ACK;
          port_status   = {STAT_CMD, port_status[5:0]};
        end
      end
      ACT_WR_DATA: begin
        // A byte is out of order when a data byte arrives with nothing
        // pending, or a status byte arrives mid-message. Inside system
        // exclusive only the end marker is held to that rule.
        mismatch = (data_bytes_left == 2'd0) != v[7];
        if (mismatch && (!sysex_active || v == MIDI_SYSEX_END)) begin
          r.byte_rejected = 1'b1;
        end else begin
          if (!v[7]) begin
            // Data bytes inside system exclusive are simply dropped.
            if (!sysex_active) begin
              pos = (slot_index > 2'd2) ? 2'd2 : slot_index;
              msg_shadow[8*pos +: 8] = v;
              slot_index      = (pos < 2'd2) ? pos + 2'd1 : 2'd2;
              data_bytes_left = data_bytes_left - 2'd1;
              if (data_bytes_left == 2'd0) begin
                r.message_valid = 1'b1;
                r.midi_message  = msg_shadow;
              end
            end
          end else if (v < MIDI_SYSEX_START) begin
            // Program change and channel pressure carry one data byte.
            open_message(v, (v >= MIDI_PROG_MIN && v < MIDI_PITCH_MIN) ? 2'd1 : 2'd2);
          end else if (v == MIDI_SYSEX_START) begin
            sysex_active = 1'b1;
          end else if (v == MIDI_SYSEX_END) begin
            sysex_active = 1'b0;
          end
          port_status[6] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------

  // Presents one access and holds it until the input transfer is taken. Valid
  // is only lowered when the sender decides to idle, so back-to-back items
  // keep it high without a second assignment in the same time step.
  task automatic send_item(action_t act, logic [7:0] v);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= v;
    do @(posedge clk); while (!in_ready);
    port_responses.push_back(decode_access(act, v));
    accepted_items++;
  endtask

  // The sender stops and waits until every predicted response has been seen.
  task automatic drain_responses();
    in_valid <= 1'b0;
    while (port_responses.size() != 0) @(posedge clk);
  endtask

  task automatic test_power_on_reads();
    send_item(ACT_RD_STAT, 8'hFF);
    send_item(ACT_RD_DATA, 8'h00);
  endtask

  // Two messages of each length, the first three with data bytes at their extremes.
  task automatic test_channel_messages();
    send_item(ACT_WR_DATA, 8'h80);
    send_item(ACT_WR_DATA, 8'h00);
    send_item(ACT_WR_DATA, 8'h7F);
    send_item(ACT_WR_DATA, MIDI_PROG_MIN);
    send_item(ACT_WR_DATA, 8'h7F);
    send_item(ACT_WR_DATA, 8'hDF);
    send_item(ACT_WR_DATA, 8'h00);
    send_item(ACT_WR_DATA, 8'hEF);
    send_item(ACT_WR_DATA, 8'h55);
    send_item(ACT_WR_DATA, 8'h2A);
  endtask

  // Data with no status pending, a status arriving mid-message, and the end
  // marker of system exclusive written outside it.
  task automatic test_out_of_order_bytes();
    send_item(ACT_WR_DATA, 8'h3C);
    send_item(ACT_WR_DATA, 8'h90);
    send_item(ACT_WR_DATA, 8'h40);
    send_item(ACT_WR_DATA, 8'h80);
    send_item(ACT_WR_DATA, 8'h7F);
    send_item(ACT_WR_DATA, MIDI_SYSEX_END);
  endtask

  // Data bytes and other system bytes are dropped inside system exclusive.
  task automatic test_sysex_stream();
    send_item(ACT_WR_DATA, MIDI_SYSEX_START);
    send_item(ACT_WR_DATA, 8'h7F);
    send_item(ACT_WR_DATA, 8'hFF);
    send_item(ACT_WR_DATA, MIDI_SYSEX_END);
  endtask

  // An ignored command, then the reset request and its acknowledge byte.
  task automatic test_commands();
    send_item(ACT_WR_CMD, 8'h12);
    send_item(ACT_WR_CMD, CMD_RESET);
    send_item(ACT_RD_STAT, 8'h00);
    send_item(ACT_RD_DATA, 8'h00);
    send_item(ACT_RD_STAT, 8'h00);
  endtask

  task automatic send_channel_message();
    logic [7:0] status;
    int         need;
    int         flaw;
    // A raw start marker may have left the port in system exclusive, where a
    // channel status byte would trap it, so close it first.
    if (sysex_active) send_item(ACT_WR_DATA, MIDI_SYSEX_END);
    status = 8'($urandom_range(8'h80, 8'hEF));
    need   = (status >= MIDI_PROG_MIN && status < MIDI_PITCH_MIN) ? 1 : 2;
    flaw   = $urandom_range(0, 11);
    send_item(ACT_WR_DATA, status);
    for (int i = 0; i < need; i++) begin
      // A stray status byte before the last data byte is refused.
      if (flaw == 0 && i == need - 1)
        send_item(ACT_WR_DATA, 8'($urandom_range(8'h80, 8'hEF)));
      // A status read in the middle of assembly must not disturb it.
      if (flaw == 1 && i == 0)
        send_item(ACT_RD_STAT, 8'($urandom));
      send_item(ACT_WR_DATA, 8'($urandom_range(0, 127)));
    end
    // A surplus data byte after the message is complete is refused.
    if (flaw == 2) send_item(ACT_WR_DATA, 8'($urandom_range(0, 127)));
  endtask

  // System exclusive is always closed again: a channel status byte inside it
  // would leave the port stuck there for the rest of the run.
  task automatic send_sysex_block();
    int         len;
    logic [7:0] b;
    send_item(ACT_WR_DATA, MIDI_SYSEX_START);
    len = $urandom_range(0, 6);
    repeat (len) begin
      if ($urandom_range(0, 4) == 0) begin
        b = 8'($urandom_range(8'hF0, 8'hFF));
        if (b == MIDI_SYSEX_END) b = MIDI_SYSEX_START;
      end else begin
        b = 8'($urandom_range(0, 127));
      end
      send_item(ACT_WR_DATA, b);
    end
    send_item(ACT_WR_DATA, MIDI_SYSEX_END);
  endtask

  task automatic run_random_phase(int count, int idle_pct, int stall_pct);
    int         start;
    int         pick;
    logic [7:0] v;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    start = accepted_items;
    while (accepted_items - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_channel_message();
      end else if (pick < 65) begin
        send_sysex_block();
      end else if (pick < 80) begin
        send_item($urandom_range(0, 1) ? ACT_RD_STAT : ACT_RD_DATA, 8'($urandom));
      end else if (pick < 88) begin
        send_item(ACT_WR_CMD, ($urandom_range(0, 2) == 0) ? CMD_RESET : 8'($urandom));
      end else begin
        // Raw byte written to the data port, kept clear of the trapping case.
        v = 8'($urandom);
        if (sysex_active && v[7] && v < MIDI_SYSEX_START) v = MIDI_SYSEX_END;
        send_item(ACT_WR_DATA, v);
      end
    end
  endtask

  // A channel status inside system exclusive opens a message while the port
  // stays in system exclusive; its data bytes are then dropped and the end
  // marker is refused for good, so this test has to come last.
  task automatic test_sysex_channel_status();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_item(ACT_WR_DATA, MIDI_SYSEX_START);
    send_item(ACT_WR_DATA, 8'h90);
    send_item(ACT_WR_DATA, 8'h40);
    send_item(ACT_WR_DATA, MIDI_SYSEX_END);
    send_item(ACT_RD_STAT, 8'h00);
  endtask

  // -------------------------------------------------------------------------
  // Result channel
  // -------------------------------------------------------------------------

  // The receiver stalls at random; the pattern follows the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Each result transfer is matched against the oldest predicted response.
  always @(posedge clk) begin : response_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (port_responses.size() == 0) begin
        $error("result transfer with no response outstanding");
        fail_count++;
      end else begin
        want = port_responses.pop_front();
        check_field("read_byte", 24'(want.read_byte), 24'(out_read_byte));
        check_field("message_valid", 24'(want.message_valid), 24'(out_message_valid));
        check_field("midi_message", want.midi_message, out_midi_message);
        check_field("reset_pulse", 24'(want.reset_pulse), 24'(out_reset_pulse));
        check_field("byte_rejected", 24'(want.byte_rejected), 24'(out_byte_rejected));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    // Power-on state of the port pair.
    port_latch      = 8'h00;
    port_status     = {STAT_RESET, 6'b000000};
    sysex_active    = 1'b0;
    data_bytes_left = 2'd0;
    msg_shadow      = 24'h000000;
    slot_index      = 2'd0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on_reads();
    test_channel_messages();
    test_out_of_order_bytes();
    test_sysex_stream();
    test_commands();

    // Random traffic under each idling pattern. Between the sender-idle and
    // receiver-stall phases the sender waits for every outstanding response.
    run_random_phase(390, 0, 0);
    run_random_phase(390, 74, 0);
    drain_responses();
    run_random_phase(390, 0, 74);
    run_random_phase(390, 7, 7);

    test_sysex_channel_status();

    drain_responses();
    // Two-register pipeline: any stray result shows up before the run ends.
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/muma_pkg.sv
hw/rtl/muma_engine.sv
hw/rtl/midi_uart_port_message_assembler.sv
tb/midi_uart_port_message_assembler_tb.sv
